// ----- rtl/mbdlp_pkg.sv -----
// Shared types, register indexes, event codes and reset values for the button debouncer.
`timescale 1ns / 1ps

package mbdlp_pkg;

	localparam int MAX_EV    = 3;
	localparam int EVQ_DEPTH = 4;

	localparam int CFG_W   = 16;
	localparam int TIME_W  = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd600;
	localparam logic [CFG_W-1:0] HOLD_RST       = 16'd2000;

	typedef enum logic [2:0] {
		EV_ACTIVITY = 3'd0,
		EV_LEFT     = 3'd1,
		EV_RIGHT    = 3'd2,
		EV_SHORT    = 3'd3,
		EV_LONG     = 3'd4,
		EV_HOLD     = 3'd5
	} ev_code_t;

	typedef struct packed {
		ev_code_t code;
		logic     last;
	} ev_t;

	// Events produced by one poll, handed to the event queue in a single push.
	typedef struct packed {
		logic                en;
		logic [1:0]          n;
		ev_t [MAX_EV-1:0]    ev;
	} ev_push_t;

endpackage

// ----- rtl/matrix_button_debounce_long_press.sv -----
// Top level of the matrix button debouncer with center long press.
//
// Input channel (in_valid/in_ready): one poll per transaction, carrying the
// millisecond timestamp now_ms and the two active-high matrix lines.
// Output channel (out_valid/out_ready): one event per transaction; last_event
// marks the final event of a poll. A poll yields zero to three events.
// Configuration: write cfg_wdata to register cfg_index when cfg_we is high;
// index 0 debounce, 1 long press, 2 hold time. Unused indexes are ignored.
// Write only while no poll is in flight.
//
// Timing: the poll is registered in the evaluation stage, its events are then
// written into the event queue, and out_valid rises once the queue holds them.
// A poll leaves the evaluation stage once the event queue has room for all its
// events, so the block takes one poll per cycle as long as the queue has room,
// and the sustained rate is set by the one-event-per-cycle output port.
// A stalled receiver fills the event queue; the evaluation stage then holds
// and in_ready drops. Reset clears all debounce state, timers and the queue
// and restores the default thresholds (20, 600, 2000 ms).
`timescale 1ns / 1ps

module matrix_button_debounce_long_press import mbdlp_pkg::*; #(
	parameter int EvqDepth = EVQ_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic                 line_a_low,
	input  logic                 line_b_low,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           event_code,
	output logic                 last_event,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] long_press_q;
	logic [CFG_W-1:0] hold_q;
	logic [1:0]       space;
	ev_push_t         push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
			hold_q       <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:   debounce_q   <= cfg_wdata;
				CFG_LONG_PRESS: long_press_q <= cfg_wdata;
				CFG_HOLD:       hold_q       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	mbdlp_eval u_eval (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.now_ms        (now_ms),
		.line_a_low    (line_a_low),
		.line_b_low    (line_b_low),
		.debounce_ms   (debounce_q),
		.long_press_ms (long_press_q),
		.hold_ms       (hold_q),
		.space         (space),
		.push          (push)
	);

	mbdlp_evq #(
		.Depth (EvqDepth)
	) u_evq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.space      (space),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_code (event_code),
		.last_event (last_event)
	);

endmodule

// ----- rtl/mbdlp_eval.sv -----
// Poll register, per-button debounce state and event generation for one poll per cycle while the event queue has room.
`timescale 1ns / 1ps

module mbdlp_eval import mbdlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              line_a_low,
	input  logic              line_b_low,
	input  logic [CFG_W-1:0]  debounce_ms,
	input  logic [CFG_W-1:0]  long_press_ms,
	input  logic [CFG_W-1:0]  hold_ms,
	input  logic [1:0]        space,
	output ev_push_t          push
);

	localparam int NCAND = 7;

	logic              valid_s1;
	logic [TIME_W-1:0] now_s1;
	logic              a_s1;
	logic              b_s1;

	logic [2:0]        raw_prev_q;
	logic [2:0]        deb_q;
	logic [TIME_W-1:0] start_q [3];
	logic [TIME_W-1:0] cpt_q;
	logic              long_fired_q;
	logic              hold_fired_q;

	logic [2:0]        raw;
	logic [2:0]        chg;
	logic [TIME_W-1:0] start_n [3];
	logic [2:0]        pass;
	logic [2:0]        deb_n;
	logic [2:0]        press;
	logic [2:0]        rel;
	logic [TIME_W-1:0] cpt_n;
	logic              lf0;
	logic              hf0;
	logic              short_ev;
	logic [TIME_W-1:0] held;
	logic              fire_long;
	logic              fire_hold;
	logic [NCAND-1:0]  cand_v;
	ev_code_t          cand_c [NCAND];
	logic [2:0]        cnt;
	ev_t [MAX_EV-1:0]  evs;
	logic              advance;

	assign advance  = valid_s1 && (cnt[1:0] <= space);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			now_s1 <= now_ms;
			a_s1   <= line_a_low;
			b_s1   <= line_b_low;
		end
	end

	assign raw[0] = a_s1 & ~b_s1;
	assign raw[1] = ~a_s1 & b_s1;
	assign raw[2] = a_s1 & b_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			chg[i]     = raw[i] != raw_prev_q[i];
			start_n[i] = chg[i] ? now_s1 : start_q[i];
			pass[i]    = (now_s1 - start_n[i]) >= {{(TIME_W-CFG_W){1'b0}}, debounce_ms};
			deb_n[i]   = pass[i] ? raw[i] : deb_q[i];
			press[i]   = pass[i] & ~deb_q[i] & raw[i];
			rel[i]     = pass[i] & deb_q[i] & ~raw[i];
		end
	end

	// A center press restarts the hold timer and re-arms both one-shot events.
	assign cpt_n     = press[2] ? now_s1 : cpt_q;
	assign lf0       = press[2] ? 1'b0 : long_fired_q;
	assign hf0       = press[2] ? 1'b0 : hold_fired_q;
	assign short_ev  = rel[2] & ~lf0;
	assign held      = now_s1 - cpt_n;
	assign fire_long = deb_n[2] & ~lf0 & (held >= {{(TIME_W-CFG_W){1'b0}}, long_press_ms});
	assign fire_hold = deb_n[2] & ~hf0 & (held >= {{(TIME_W-CFG_W){1'b0}}, hold_ms});

	// Candidate events in emission order; only the first three are kept.
	always_comb begin
		cand_v    = {fire_hold, fire_long, press[2] | short_ev, press[1], press[1],
			press[0], press[0]};
		cand_c[0] = EV_ACTIVITY;
		cand_c[1] = EV_LEFT;
		cand_c[2] = EV_ACTIVITY;
		cand_c[3] = EV_RIGHT;
		cand_c[4] = press[2] ? EV_ACTIVITY : EV_SHORT;
		cand_c[5] = EV_LONG;
		cand_c[6] = EV_HOLD;
	end

	always_comb begin
		cnt = 3'd0;
		evs = '0;
		for (int k = 0; k < NCAND; k++) begin
			if (cand_v[k] && cnt < 3'(MAX_EV)) begin
				evs[cnt[1:0]].code = cand_c[k];
				cnt = cnt + 3'd1;
			end
		end
		if (cnt != 3'd0) begin
			evs[cnt[1:0] - 2'd1].last = 1'b1;
		end
	end

	assign push.en = advance;
	assign push.n  = cnt[1:0];
	assign push.ev = evs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_prev_q   <= '0;
			deb_q        <= '0;
			for (int i = 0; i < 3; i++) begin
				start_q[i] <= '0;
			end
			cpt_q        <= '0;
			long_fired_q <= 1'b0;
			hold_fired_q <= 1'b0;
		end else if (advance) begin
			raw_prev_q   <= raw;
			deb_q        <= deb_n;
			for (int i = 0; i < 3; i++) begin
				start_q[i] <= start_n[i];
			end
			cpt_q        <= cpt_n;
			long_fired_q <= lf0 | fire_long;
			hold_fired_q <= hf0 | fire_hold;
		end
	end

endmodule

// ----- rtl/mbdlp_evq.sv -----
// Event queue that takes up to three events per cycle and delivers one per transaction.
`timescale 1ns / 1ps

module mbdlp_evq import mbdlp_pkg::*; #(
	parameter int Depth = EVQ_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ev_push_t   push,
	output logic [1:0] space,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_code,
	output logic       last_event
);

	// Depth must be a power of two, at least MAX_EV, so the pointers wrap naturally.
	localparam int AW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);

	ev_t           mem [Depth];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [1:0]    pushed;
	logic [CW:0]   free;

	assign pop    = (count_q != '0) && out_ready;
	assign pushed = push.en ? push.n : 2'd0;
	assign free   = (CW+1)'(Depth) - {1'b0, count_q} + (CW+1)'(pop);
	assign space  = (free >= (CW+1)'(MAX_EV)) ? 2'(MAX_EV) : free[1:0];

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_EV; k++) begin
			if (k < int'(pushed)) begin
				mem[wr_ptr_q + AW'(k)] <= push.ev[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(pushed);
			rd_ptr_q <= rd_ptr_q + AW'(pop);
			count_q  <= count_q + CW'(pushed) - CW'(pop);
		end
	end

	assign out_valid  = count_q != '0;
	assign event_code = mem[rd_ptr_q].code;
	assign last_event = mem[rd_ptr_q].last;

endmodule

// ----- rtl/mbdlp_chk.sv -----
// Port-level checker for the button debouncer, bound to the top level.
`timescale 1ns / 1ps

module mbdlp_chk import mbdlp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [TIME_W-1:0]    now_ms,
	input logic                 line_a_low,
	input logic                 line_b_low,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [2:0]           event_code,
	input logic                 last_event
);

	logic       out_acc;
	logic [2:0] prev_code_q;
	logic       prev_last_q;
	logic [1:0] run_q;

	assign out_acc = out_valid && out_ready;

	// Track the previous delivered event and how many events of the current poll went out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_code_q <= EV_ACTIVITY;
			prev_last_q <= 1'b1;
			run_q       <= 2'd0;
		end else if (out_acc) begin
			prev_code_q <= event_code;
			prev_last_q <= last_event;
			run_q       <= last_event ? 2'd0 : run_q + 2'd1;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(now_ms) && $stable(line_a_low)
			&& $stable(line_b_low))
		else $error("input transaction changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_code) && $stable(last_event))
		else $error("output transaction changed while stalled");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= EV_HOLD)
		else $error("event code out of range");

	a_button_after_activity: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && (event_code == EV_LEFT || event_code == EV_RIGHT)
		|-> prev_code_q == EV_ACTIVITY && !prev_last_q)
		else $error("left or right event without preceding activity event");

	a_poll_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !last_event |-> run_q < 2'd2)
		else $error("more than three events in one poll");

endmodule

bind matrix_button_debounce_long_press mbdlp_chk u_chk (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the matrix button debouncer with center long press.
`timescale 1ns / 1ps

module tb_top;
	import mbdlp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_CYCLES     = 10;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int NUM_DIRECTED   = 32;

	// Index 3 is not a register; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum logic {
		ROW_POLL,
		ROW_CFG
	} row_kind_t;

	// For a poll row, val is the timestamp; for a register row, it is the write data.
	typedef struct packed {
		row_kind_t                kind;
		logic [CFG_IDX_W-1:0]     idx;
		logic [TIME_W-1:0]        val;
		logic                     a;
		logic                     b;
		logic                     typed;
		logic [1:0]               n;
		ev_code_t [0:MAX_EV-1]    evs;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [TIME_W-1:0]    now_ms;
	logic                 line_a_low;
	logic                 line_b_low;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [2:0]           event_code;
	logic                 last_event;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	// Shadow copy of the debouncer state and thresholds.
	logic [CFG_W-1:0]  m_debounce;
	logic [CFG_W-1:0]  m_long;
	logic [CFG_W-1:0]  m_hold;
	logic              m_raw_prev [3];
	logic [TIME_W-1:0] m_start [3];
	logic              m_level [3];
	logic [TIME_W-1:0] m_press_time;
	logic              m_long_fired;
	logic              m_hold_fired;

	ev_code_t pred_codes [MAX_EV];
	int       pred_n;
	ev_t      pending_events [$];

	int errors;
	int tx_idle_pct;
	int rx_stall_pct;
	int hold_req;
	int hold_ack;
	int hold_left;
	int idle_cycles;

	logic [TIME_W-1:0] cur_t;
	logic              cur_a;
	logic              cur_b;

	stim_row_t directed_rows [NUM_DIRECTED] = '{
		'{ROW_POLL, CFG_DEBOUNCE, 32'd0, 1'b0, 1'b0, 1'b1, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd5, 1'b1, 1'b0, 1'b1, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd25, 1'b1, 1'b0, 1'b1, 2'd2,
			'{EV_ACTIVITY, EV_LEFT, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd30, 1'b0, 1'b0, 1'b1, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd50, 1'b0, 1'b0, 1'b1, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd60, 1'b0, 1'b1, 1'b1, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd80, 1'b0, 1'b1, 1'b1, 2'd2,
			'{EV_ACTIVITY, EV_RIGHT, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd100, 1'b1, 1'b1, 1'b1, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd120, 1'b1, 1'b1, 1'b1, 2'd1,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd720, 1'b1, 1'b1, 1'b1, 2'd1,
			'{EV_LONG, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd2120, 1'b1, 1'b1, 1'b1, 2'd1,
			'{EV_HOLD, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd2130, 1'b0, 1'b0, 1'b1, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd2150, 1'b0, 1'b0, 1'b1, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd2200, 1'b1, 1'b1, 1'b1, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd2220, 1'b1, 1'b1, 1'b1, 2'd1,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd2300, 1'b0, 1'b0, 1'b1, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd2320, 1'b0, 1'b0, 1'b1, 2'd1,
			'{EV_SHORT, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'h0000_0004, 1'b1, 1'b0, 1'b1, 2'd2,
			'{EV_ACTIVITY, EV_LEFT, EV_ACTIVITY}},
		'{ROW_CFG, CFG_UNUSED, 32'h0000_FFFF, 1'b0, 1'b0, 1'b0, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_CFG, CFG_DEBOUNCE, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_CFG, CFG_LONG_PRESS, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_CFG, CFG_HOLD, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'h8000_0000, 1'b1, 1'b1, 1'b1, 2'd3,
			'{EV_ACTIVITY, EV_LONG, EV_HOLD}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_CFG, CFG_DEBOUNCE, 32'h0000_FFFF, 1'b0, 1'b0, 1'b0, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_CFG, CFG_LONG_PRESS, 32'h0000_FFFF, 1'b0, 1'b0, 1'b0, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_CFG, CFG_HOLD, 32'h0000_FFFF, 1'b0, 1'b0, 1'b0, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'd0, 1'b1, 1'b1, 1'b0, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'h0000_FFFF, 1'b1, 1'b1, 1'b0, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'h0001_FFFE, 1'b1, 1'b1, 1'b0, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}},
		'{ROW_POLL, CFG_DEBOUNCE, 32'h0001_FFFF, 1'b0, 1'b0, 1'b0, 2'd0,
			'{EV_ACTIVITY, EV_ACTIVITY, EV_ACTIVITY}}
	};

	matrix_button_debounce_long_press i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.now_ms     (now_ms),
		.line_a_low (line_a_low),
		.line_b_low (line_b_low),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_code (event_code),
		.last_event (last_event),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic void shadow_reset();
		m_debounce = DEBOUNCE_RST;
		m_long     = LONG_PRESS_RST;
		m_hold     = HOLD_RST;
		for (int i = 0; i < 3; i++) begin
			m_raw_prev[i] = 1'b0;
			m_start[i]    = '0;
			m_level[i]    = 1'b0;
		end
		m_press_time = '0;
		m_long_fired = 1'b0;
		m_hold_fired = 1'b0;
	endfunction

	function automatic void add_pred(ev_code_t code);
		if (pred_n < MAX_EV) begin
			pred_codes[pred_n] = code;
			pred_n++;
		end
	endfunction

	// Computes the events of one poll and advances the shadow state.
	function automatic void debounce_predict(logic [TIME_W-1:0] t, logic a, logic b);
		logic              raw [3];
		logic              prv;
		logic [TIME_W-1:0] diff;
		raw[0] = a & ~b;
		raw[1] = ~a & b;
		raw[2] = a & b;
		pred_n = 0;
		for (int i = 0; i < 3; i++) begin
			if (raw[i] != m_raw_prev[i]) begin
				m_start[i]    = t;
				m_raw_prev[i] = raw[i];
			end
			diff = t - m_start[i];
			if (diff >= {16'd0, m_debounce}) begin
				prv = m_level[i];
				m_level[i] = raw[i];
				if (!prv && raw[i]) begin
					add_pred(EV_ACTIVITY);
					if (i == 0) begin
						add_pred(EV_LEFT);
					end else if (i == 1) begin
						add_pred(EV_RIGHT);
					end else begin
						m_press_time = t;
						m_long_fired = 1'b0;
						m_hold_fired = 1'b0;
					end
				end else if (prv && !raw[i] && i == 2 && !m_long_fired) begin
					add_pred(EV_SHORT);
				end
			end
		end
		if (m_level[2]) begin
			diff = t - m_press_time;
			if (!m_long_fired && diff >= {16'd0, m_long}) begin
				m_long_fired = 1'b1;
				add_pred(EV_LONG);
			end
			if (!m_hold_fired && diff >= {16'd0, m_hold}) begin
				m_hold_fired = 1'b1;
				add_pred(EV_HOLD);
			end
		end
	endfunction

	task automatic send_poll(stim_row_t row);
		ev_t ev;
		int  cnt;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		now_ms     <= row.val;
		line_a_low <= row.a;
		line_b_low <= row.b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		debounce_predict(row.val, row.a, row.b);
		cnt = row.typed ? int'(row.n) : pred_n;
		for (int k = 0; k < cnt; k++) begin
			ev.code = row.typed ? row.evs[k] : pred_codes[k];
			ev.last = (k == cnt - 1);
			pending_events.push_back(ev);
		end
	endtask

	// Waits until every expected event is out and any silent poll has cleared the pipeline.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_DEBOUNCE:   m_debounce = val;
			CFG_LONG_PRESS: m_long     = val;
			CFG_HOLD:       m_hold     = val;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_config(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lp,
			logic [CFG_W-1:0] hd);
		settle();
		write_reg(CFG_DEBOUNCE, deb);
		write_reg(CFG_LONG_PRESS, lp);
		write_reg(CFG_HOLD, hd);
	endtask

	// Mostly forward-moving time with levels held across polls, plus glitches and jumps.
	function automatic stim_row_t next_random_row();
		stim_row_t row;
		int        sel;
		int        r;
		row = '0;
		row.kind = ROW_POLL;
		sel = $urandom_range(9);
		if (sel <= 3)
			cur_t = cur_t + $urandom_range(0, 3);
		else if (sel <= 6)
			cur_t = cur_t + m_debounce + $urandom_range(0, 8);
		else if (sel == 7)
			cur_t = cur_t + m_long + $urandom_range(0, 40);
		else if (sel == 8)
			cur_t = cur_t + m_hold + $urandom_range(0, 40);
		else
			cur_t = $urandom();
		row.val = cur_t;
		r = $urandom_range(99);
		if (r < 20) begin
			cur_a = 1'($urandom_range(1));
			cur_b = 1'($urandom_range(1));
		end
		row.a = cur_a;
		row.b = cur_b;
		if (r >= 20 && r < 26) begin
			row.a = 1'($urandom_range(1));
			row.b = 1'($urandom_range(1));
		end
		return row;
	endfunction

	task automatic run_phase(int items, int tx_pct, int rx_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (int k = 0; k < items; k++)
			send_poll(next_random_row());
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack  = hold_req;
			hold_left = HOLDOFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : event_check
		ev_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected event: event_code %0d, last_event %0d", event_code,
					last_event);
				errors++;
			end else begin
				want = pending_events.pop_front();
				if (event_code !== want.code) begin
					$error("event_code mismatch: expected %0d, actual %0d", want.code,
						event_code);
					errors++;
				end
				if (last_event !== want.last) begin
					$error("last_event mismatch: expected %0d, actual %0d", want.last,
						last_event);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		now_ms       = '0;
		line_a_low   = 1'b0;
		line_b_low   = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_DEBOUNCE;
		cfg_wdata    = '0;
		errors       = 0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_req     = 0;
		hold_ack     = 0;
		hold_left    = 0;
		idle_cycles  = 0;
		cur_t        = '0;
		cur_a        = 1'b0;
		cur_b        = 1'b0;
		shadow_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < NUM_DIRECTED; k++) begin
			row = directed_rows[k];
			if (row.kind == ROW_CFG) begin
				settle();
				write_reg(row.idx, row.val[CFG_W-1:0]);
			end else begin
				send_poll(row);
			end
		end

		apply_config(16'd0, 16'd0, 16'd0);
		run_phase(14, 0, 0);
		apply_config(CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(1, 300)),
			CFG_W'($urandom_range(1, 600)));
		run_phase(14, 49, 0);
		apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(14, 0, 49);
		apply_config(CFG_W'($urandom_range(0, 5)), CFG_W'($urandom_range(0, 100)),
			CFG_W'($urandom_range(0, 150)));
		run_phase(14, 9, 9);

		// Receiver holds off while left presses and releases keep coming, so the
		// event queue fills and the input side has to stall.
		apply_config(16'd0, LONG_PRESS_RST, HOLD_RST);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_req++;
		for (int k = 0; k < 16; k++) begin
			row = '0;
			row.kind = ROW_POLL;
			cur_t = cur_t + 1;
			row.val = cur_t;
			row.a = (k % 2 == 0);
			send_poll(row);
		end
		settle();

		while (pending_events.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
